@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the page reference table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define PRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define PRT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/prt_pkg.sv @@
// Shared types and constants of the page reference table.
`default_nettype none

package prt_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;

  localparam int FRAME_W    = 44;
  localparam int COUNT_W    = 16;
  localparam int REQ_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int FREE_OUT_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Request codes
  localparam logic [REQ_W-1:0] REQ_RECORD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADD     = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOPAGE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd4;

  // Request word held stable while the scan runs
  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [FRAME_W-1:0] frame;
  } req_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic                valid;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  cnt;
    logic                ret;
  } token_t;

endpackage

`default_nettype wire

@@ rtl/core/prt_cell.sv @@
// One table entry: frame and count, acting on the scan token as it passes.
`default_nettype none

module prt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  prt_pkg::req_t   req,
  input  prt_pkg::token_t tok_i,
  output prt_pkg::token_t tok_o
);

  logic [prt_pkg::FRAME_W-1:0] frame_r, frame_nxt;
  logic [prt_pkg::COUNT_W-1:0] count_r, count_nxt;
  prt_pkg::token_t             tok_r, tok_nxt;
  logic                        live;
  logic                        is_free;
  logic                        is_match;

  // Claim, decrement or increment this entry when the token is still open
  always_comb begin
    frame_nxt = frame_r;
    count_nxt = count_r;
    tok_nxt   = tok_i;
    live      = tok_i.valid && !tok_i.done;
    is_free   = (frame_r == '0);
    is_match  = !is_free && (frame_r == req.frame);
    if (live) begin
      case (req.kind)
        prt_pkg::REQ_RECORD: begin
          if (is_free) begin
            frame_nxt      = req.frame;
            count_nxt      = prt_pkg::COUNT_W'(1);
            tok_nxt.done   = 1'b1;
            tok_nxt.status = prt_pkg::ST_OK;
            tok_nxt.cnt    = prt_pkg::COUNT_W'(1);
          end
        end
        prt_pkg::REQ_RELEASE: begin
          if (is_match) begin
            tok_nxt.done = 1'b1;
            if (count_r == '0) begin
              tok_nxt.status = prt_pkg::ST_COUNT;
              tok_nxt.cnt    = '0;
            end else begin
              count_nxt      = count_r - prt_pkg::COUNT_W'(1);
              tok_nxt.status = prt_pkg::ST_OK;
              tok_nxt.cnt    = count_r - prt_pkg::COUNT_W'(1);
              if (count_r == prt_pkg::COUNT_W'(1)) begin
                frame_nxt   = '0;
                tok_nxt.ret = 1'b1;
              end
            end
          end
        end
        prt_pkg::REQ_ADD: begin
          if (is_match) begin
            tok_nxt.done = 1'b1;
            if (count_r == prt_pkg::COUNT_MAX) begin
              tok_nxt.status = prt_pkg::ST_COUNT;
              tok_nxt.cnt    = prt_pkg::COUNT_MAX;
            end else begin
              count_nxt      = count_r + prt_pkg::COUNT_W'(1);
              tok_nxt.status = prt_pkg::ST_OK;
              tok_nxt.cnt    = count_r + prt_pkg::COUNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold entry state; advance the token one cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      count_r     <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      frame_r <= frame_nxt;
      count_r <= count_nxt;
      tok_r   <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

@@ rtl/core/page_reference_table.sv @@
// Page frame reference-count table: a row of entry cells scanned by a token.
// A word passes the injection stage, then each cell in turn; out_strobe and the
// result word are registered together as its token leaves the row.
// A new word is accepted only while busy is low; busy falls in the strobe cycle.
// Reset (synchronous, rst_n low): all entries free with count 0, free count full.
// Results cannot be stalled by the receiver; each strobe lasts one cycle.
`default_nettype none

module page_reference_table #(
  parameter int TABLE_ENTRIES = prt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [prt_pkg::REQ_W-1:0]      in_req_type,
  input  logic [prt_pkg::FRAME_W-1:0]    in_page_frame,
  output logic                           out_strobe,
  output logic [prt_pkg::STATUS_W-1:0]   out_status,
  output logic [prt_pkg::FRAME_W-1:0]    out_granted_frame,
  output logic                           out_return_to_allocator,
  output logic [prt_pkg::COUNT_W-1:0]    out_new_count,
  output logic [prt_pkg::FREE_OUT_W-1:0] out_free_entries
);

  localparam int FREE_W = $clog2(TABLE_ENTRIES + 1);

  logic                           busy_r, busy_nxt;
  logic                           accept;
  prt_pkg::req_t                  req_r;
  prt_pkg::token_t                inj_r, inj_nxt;
  prt_pkg::token_t                tok [TABLE_ENTRIES+1];
  prt_pkg::token_t                last;
  logic [FREE_W-1:0]              free_r, free_nxt;
  logic [FREE_W+prt_pkg::FREE_OUT_W-1:0] free_ext;
  logic [prt_pkg::STATUS_W-1:0]   fin_status;
  logic [prt_pkg::FRAME_W-1:0]    fin_granted;
  logic                           rec_ok;
  logic                           out_strobe_r;
  logic [prt_pkg::STATUS_W-1:0]   out_status_r;
  logic [prt_pkg::FRAME_W-1:0]    out_granted_r;
  logic                           out_ret_r;
  logic [prt_pkg::COUNT_W-1:0]    out_count_r;
  logic [prt_pkg::FREE_OUT_W-1:0] out_free_r;
  logic                           ret_clean;

  assign accept = start && !busy_r;

  // Open a token; close it at once for frame zero and for the unused code
  always_comb begin
    inj_nxt.valid  = accept;
    inj_nxt.done   = 1'b0;
    inj_nxt.status = prt_pkg::ST_OK;
    inj_nxt.cnt    = '0;
    inj_nxt.ret    = 1'b0;
    if (in_req_type == prt_pkg::REQ_NONE) begin
      inj_nxt.done = 1'b1;
    end else if (in_page_frame == '0) begin
      inj_nxt.done   = 1'b1;
      inj_nxt.status = (in_req_type == prt_pkg::REQ_RECORD) ? prt_pkg::ST_NOPAGE
                                                            : prt_pkg::ST_UNKNOWN;
    end
  end

  assign tok[0] = inj_r;

  // Row of entry cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    prt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req_r),
      .tok_i (tok[g]),
      .tok_o (tok[g+1])
    );
  end

  assign last = tok[TABLE_ENTRIES];

  // Settle the result of a token leaving the row
  always_comb begin
    if (last.done) begin
      fin_status = last.status;
    end else if (req_r.kind == prt_pkg::REQ_RECORD) begin
      fin_status = prt_pkg::ST_FULL;
    end else begin
      fin_status = prt_pkg::ST_UNKNOWN;
    end
    rec_ok      = (req_r.kind == prt_pkg::REQ_RECORD) && (fin_status == prt_pkg::ST_OK);
    fin_granted = rec_ok ? req_r.frame : '0;
    free_nxt    = free_r;
    if (last.valid) begin
      if (rec_ok) begin
        free_nxt = free_r - FREE_W'(1);
      end else if (last.ret) begin
        free_nxt = free_r + FREE_W'(1);
      end
    end
    free_ext = {{prt_pkg::FREE_OUT_W{1'b0}}, free_nxt};
  end

  // Drop busy when the result goes out; raise it on accept
  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (last.valid) begin
      busy_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      inj_r.valid  <= 1'b0;
      out_strobe_r <= 1'b0;
      free_r       <= FREE_W'(TABLE_ENTRIES);
    end else begin
      busy_r       <= busy_nxt;
      inj_r        <= inj_nxt;
      out_strobe_r <= last.valid;
      free_r       <= free_nxt;
    end
  end

  // Hold the request word and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.kind  <= in_req_type;
      req_r.frame <= in_page_frame;
    end
    if (last.valid) begin
      out_status_r  <= fin_status;
      out_granted_r <= fin_granted;
      out_ret_r     <= last.ret;
      out_count_r   <= last.cnt;
      out_free_r    <= free_ext[prt_pkg::FREE_OUT_W-1:0];
    end
  end

  assign busy                    = busy_r;
  assign out_strobe              = out_strobe_r;
  assign out_status              = out_status_r;
  assign out_granted_frame       = out_granted_r;
  assign out_return_to_allocator = out_ret_r;
  assign out_new_count           = out_count_r;
  assign out_free_entries        = out_free_r;

  // A returned frame always comes with a clean zero count
  assign ret_clean = (out_status_r == prt_pkg::ST_OK) && (out_count_r == '0);

`include "assert_macros.svh"

  `PRT_ASSERT(a_busy_on_accept, accept |=> busy_r, "busy not raised after accept")
  `PRT_ASSERT(a_strobe_single, out_strobe_r |=> !out_strobe_r, "result strobe repeated")
  `PRT_NEVER(a_free_range, free_r > FREE_W'(TABLE_ENTRIES), "free count above table size")
  `PRT_ASSERT(a_ret_ok, out_strobe_r && out_ret_r |-> ret_clean, "return without zero count")

endmodule

`default_nettype wire
